// ===== sv/tlqv_pkg.sv =====
// thick line quad setup: shared widths, payload structs, corner codes and saturation
// used by tlqv_cordic_stage and thick_line_quad_vertices; no dependencies
`timescale 1ns / 1ps

package tlqv_pkg;

  localparam int COORD_W     = 16;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int THICK_W     = 8;
  localparam int CORNER_W    = 3;
  localparam int PRE_SHIFT   = 8;
  // vectoring magnitude stays below 2^26 after gain
  localparam int VEC_W       = 28;
  // rotation magnitude stays below 2^27, headroom for the rounding bias
  localparam int ROT_W       = 29;
  localparam int ROUND_SHIFT = 16;
  localparam int OFF_W       = ROT_W - ROUND_SHIFT;
  localparam int HALF_W      = THICK_W - 1 + 4;
  localparam int KINV_W      = 16;

  localparam logic [KINV_W-1:0]       KINV_Q16   = 16'd39797;
  localparam logic signed [ROT_W-1:0] ROUND_BIAS = 29'sd32768;

  // corner order: src-s, src+s, dst+s, dst-s, dst+s, src-s
  localparam logic [CORNER_W-1:0] C_SRC_MINUS_A = 3'd0;
  localparam logic [CORNER_W-1:0] C_SRC_PLUS    = 3'd1;
  localparam logic [CORNER_W-1:0] C_DST_PLUS_A  = 3'd2;
  localparam logic [CORNER_W-1:0] C_DST_MINUS   = 3'd3;
  localparam logic [CORNER_W-1:0] C_DST_PLUS_B  = 3'd4;
  localparam logic [CORNER_W-1:0] C_SRC_MINUS_B = 3'd5;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    MODE_ROT,
    MODE_VPOS,
    MODE_VNEG,
    MODE_ZERO
  } off_mode_e;

  typedef struct packed {
    coord_t                     src_x;
    coord_t                     src_y;
    coord_t                     dst_x;
    coord_t                     dst_y;
    logic signed [DIFF_W-1:0]   dx;
    logic signed [DIFF_W-1:0]   dy;
    logic [HALF_W-1:0]          big_h;
    logic [HALF_W+KINV_W-1:0]   c0;
  } front_t;

  typedef struct packed {
    coord_t                     src_x;
    coord_t                     src_y;
    coord_t                     dst_x;
    coord_t                     dst_y;
    off_mode_e                  mode;
    logic [HALF_W-1:0]          big_h;
    logic signed [VEC_W-1:0]    vx;
    logic signed [VEC_W-1:0]    vy;
    logic signed [ROT_W-1:0]    c;
    logic signed [ROT_W-1:0]    s;
  } cordic_t;

  function automatic coord_t sat_coord(input logic signed [DIFF_W-1:0] v);
    coord_t r;
    if (v[DIFF_W-1] != v[DIFF_W-2]) begin
      r = v[DIFF_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/tlqv_cordic_stage.sv =====
// one registered cordic iteration: vectoring on (vx, vy) steers rotation of (c, s)
// depends on tlqv_pkg
`timescale 1ns / 1ps

module tlqv_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tlqv_pkg::cordic_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tlqv_pkg::cordic_t out_data_o
);
  import tlqv_pkg::*;

  cordic_t data_d, data_q;
  logic    valid_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    data_d = in_data_i;
    if (!in_data_i.vy[VEC_W-1]) begin
      data_d.vx = in_data_i.vx + (in_data_i.vy >>> SHIFT);
      data_d.vy = in_data_i.vy - (in_data_i.vx >>> SHIFT);
      data_d.c  = in_data_i.c - (in_data_i.s >>> SHIFT);
      data_d.s  = in_data_i.s + (in_data_i.c >>> SHIFT);
    end else begin
      data_d.vx = in_data_i.vx - (in_data_i.vy >>> SHIFT);
      data_d.vy = in_data_i.vy + (in_data_i.vx >>> SHIFT);
      data_d.c  = in_data_i.c + (in_data_i.s >>> SHIFT);
      data_d.s  = in_data_i.s - (in_data_i.c >>> SHIFT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== sv/thick_line_quad_vertices.sv =====
// thick line quad setup top level: difference, fold, cordic pipeline, rounding and
// a six-corner serialiser with an output register; depends on tlqv_pkg, tlqv_cordic_stage
//
// channel   dir  handshake                   payload
// in        in   in_valid_i / in_ready_o     src_x_i, src_y_i, dst_x_i, dst_y_i
// out       out  out_valid_o / out_ready_i   vertex_x_o, vertex_y_o, corner_index_o,
//                                            last_vertex_o
// cfg       in   cfg_valid_i / cfg_ready_o   cfg_line_thickness_i
//
// a segment passes a difference stage, a fold stage, ANGLE_STEPS cordic stages and a
// rounding stage before its first vertex reaches the output register
// the serialiser emits one vertex per cycle unless the output stalls; the segment
// register takes the next segment as the last corner of the current one goes out
// every stage holds on a stall; a request waits in the pipeline, none is lost
// reset clears all valid bits and sets line_thickness to 1
`timescale 1ns / 1ps

module thick_line_quad_vertices #(
  parameter int ANGLE_STEPS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tlqv_pkg::coord_t                src_x_i,
  input  tlqv_pkg::coord_t                src_y_i,
  input  tlqv_pkg::coord_t                dst_x_i,
  input  tlqv_pkg::coord_t                dst_y_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tlqv_pkg::coord_t                vertex_x_o,
  output tlqv_pkg::coord_t                vertex_y_o,
  output logic [tlqv_pkg::CORNER_W-1:0]   corner_index_o,
  output logic                            last_vertex_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tlqv_pkg::THICK_W-1:0]    cfg_line_thickness_i
);
  import tlqv_pkg::*;

  // configuration
  logic [THICK_W-1:0] thick_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thick_q <= THICK_W'(1);
    end else if (cfg_valid_i) begin
      thick_q <= cfg_line_thickness_i;
    end
  end

  // difference stage
  front_t front_d, front_q;
  logic   front_valid_q;
  logic   fold_ready;

  assign in_ready_o = !front_valid_q || fold_ready;

  always_comb begin
    front_d.src_x = src_x_i;
    front_d.src_y = src_y_i;
    front_d.dst_x = dst_x_i;
    front_d.dst_y = dst_y_i;
    front_d.dx    = DIFF_W'(dst_x_i) - DIFF_W'(src_x_i);
    front_d.dy    = DIFF_W'(dst_y_i) - DIFF_W'(src_y_i);
    front_d.big_h = {thick_q[THICK_W-1:1], 4'b0000};
    front_d.c0    = front_d.big_h * KINV_Q16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      front_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      front_q <= front_d;
    end
  end

  // fold stage: right half plane, pre-scale, special cases
  cordic_t                  fold_d, fold_q;
  logic                     fold_valid_q;
  logic signed [DIFF_W-1:0] ax, ay;

  cordic_t stage_data  [ANGLE_STEPS+1];
  logic    stage_valid [ANGLE_STEPS+1];
  logic    stage_ready [ANGLE_STEPS+1];

  assign fold_ready = !fold_valid_q || stage_ready[0];

  always_comb begin
    ax = front_q.dx[DIFF_W-1] ? -front_q.dx : front_q.dx;
    ay = front_q.dx[DIFF_W-1] ? -front_q.dy : front_q.dy;
    fold_d.src_x = front_q.src_x;
    fold_d.src_y = front_q.src_y;
    fold_d.dst_x = front_q.dst_x;
    fold_d.dst_y = front_q.dst_y;
    fold_d.big_h = front_q.big_h;
    fold_d.vx    = VEC_W'(ax) <<< PRE_SHIFT;
    fold_d.vy    = VEC_W'(ay) <<< PRE_SHIFT;
    fold_d.c     = ROT_W'(front_q.c0);
    fold_d.s     = '0;
    if (front_q.dx != '0) begin
      fold_d.mode = MODE_ROT;
    end else if (front_q.dy == '0) begin
      fold_d.mode = MODE_ZERO;
    end else if (front_q.dy[DIFF_W-1]) begin
      fold_d.mode = MODE_VNEG;
    end else begin
      fold_d.mode = MODE_VPOS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_valid_q <= 1'b0;
    end else if (fold_ready) begin
      fold_valid_q <= front_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fold_ready && front_valid_q) begin
      fold_q <= fold_d;
    end
  end

  // cordic pipeline
  assign stage_data[0]  = fold_q;
  assign stage_valid[0] = fold_valid_q;

  for (genvar i = 0; i < ANGLE_STEPS; i++) begin : g_iter
    tlqv_cordic_stage #(
      .SHIFT(i)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stage_valid[i]),
      .in_ready_o  (stage_ready[i]),
      .in_data_i   (stage_data[i]),
      .out_valid_o (stage_valid[i+1]),
      .out_ready_i (stage_ready[i+1]),
      .out_data_o  (stage_data[i+1])
    );
  end

  // rounding stage into the segment register
  cordic_t                 fin;
  logic signed [ROT_W-1:0] s_bias, c_bias;
  logic signed [OFF_W-1:0] half_s;
  logic signed [OFF_W-1:0] offx_d, offy_d, offx_q, offy_q;
  coord_t                  sx_q, sy_q, ex_q, ey_q;
  logic                    seg_valid_q, seg_ready, seg_done;
  logic [CORNER_W-1:0]     corner_q;
  logic                    out_load, emit;

  assign fin    = stage_data[ANGLE_STEPS];
  assign s_bias = fin.s + ROUND_BIAS;
  assign c_bias = fin.c + ROUND_BIAS;
  assign half_s = $signed(OFF_W'(fin.big_h));

  always_comb begin
    case (fin.mode)
      MODE_ROT: begin
        offx_d = $signed(s_bias[ROT_W-1:ROUND_SHIFT]);
        offy_d = $signed(c_bias[ROT_W-1:ROUND_SHIFT]);
      end
      MODE_VPOS: begin
        offx_d = half_s;
        offy_d = '0;
      end
      MODE_VNEG: begin
        offx_d = -half_s;
        offy_d = '0;
      end
      default: begin
        offx_d = '0;
        offy_d = half_s;
      end
    endcase
  end

  assign out_load  = !out_valid_o || out_ready_i;
  assign emit      = seg_valid_q && out_load;
  assign seg_done  = emit && (corner_q == C_SRC_MINUS_B);
  assign seg_ready = !seg_valid_q || seg_done;
  assign stage_ready[ANGLE_STEPS] = seg_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_valid_q <= 1'b0;
      corner_q    <= C_SRC_MINUS_A;
    end else begin
      if (seg_ready) begin
        seg_valid_q <= stage_valid[ANGLE_STEPS];
      end
      if (seg_done) begin
        corner_q <= C_SRC_MINUS_A;
      end else if (emit) begin
        corner_q <= corner_q + CORNER_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_ready && stage_valid[ANGLE_STEPS]) begin
      sx_q   <= fin.src_x;
      sy_q   <= fin.src_y;
      ex_q   <= fin.dst_x;
      ey_q   <= fin.dst_y;
      offx_q <= offx_d;
      offy_q <= offy_d;
    end
  end

  // corner serialiser
  logic                     use_src, minus_side;
  coord_t                   px, py;
  logic signed [DIFF_W-1:0] sum_x, sum_y;
  logic signed [OFF_W-1:0]  ox, oy;

  always_comb begin
    case (corner_q) inside
      C_SRC_MINUS_A, C_SRC_PLUS, C_SRC_MINUS_B: use_src = 1'b1;
      default:                                  use_src = 1'b0;
    endcase
    case (corner_q) inside
      C_SRC_MINUS_A, C_DST_MINUS, C_SRC_MINUS_B: minus_side = 1'b1;
      default:                                   minus_side = 1'b0;
    endcase
    px    = use_src ? sx_q : ex_q;
    py    = use_src ? sy_q : ey_q;
    // p-s moves x down and y up, p+s the other way
    ox    = minus_side ? -offx_q : offx_q;
    oy    = minus_side ? offy_q : -offy_q;
    sum_x = DIFF_W'(px) + DIFF_W'(ox);
    sum_y = DIFF_W'(py) + DIFF_W'(oy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      vertex_x_o     <= sat_coord(sum_x);
      vertex_y_o     <= sat_coord(sum_y);
      corner_index_o <= corner_q;
      last_vertex_o  <= (corner_q == C_SRC_MINUS_B);
    end
  end

  // checks
  a_corner_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    corner_q <= C_SRC_MINUS_B)
    else $error("corner counter out of range");

  a_corner_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_vertex_o |=>
      !out_valid_o || corner_index_o == $past(corner_index_o) + CORNER_W'(1))
    else $error("vertex order broken within a segment");

  a_seg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid_q && !out_load |=> seg_valid_q && $stable(corner_q))
    else $error("segment advanced while output stalled");

  a_seg_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(seg_valid_q) |-> corner_q == C_SRC_MINUS_A)
    else $error("new segment does not start at the first corner");

endmodule

// ===== dv/thick_line_quad_vertices_test.sv =====
// self-checking bench for thick_line_quad_vertices: six-corner prediction per segment,
// random valid/ready pressure and thickness changes between phases; depends on tlqv_pkg
`timescale 1ns / 1ps

module thick_line_quad_vertices_test;
  import tlqv_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int DRAIN_CYCLES = CORDIC_STEPS + 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    coord_t src_x;
    coord_t src_y;
    coord_t dst_x;
    coord_t dst_y;
  } segment_t;

  typedef struct {
    coord_t              x;
    coord_t              y;
    logic [CORNER_W-1:0] index;
    logic                last;
  } corner_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  coord_t              src_x_i = '0;
  coord_t              src_y_i = '0;
  coord_t              dst_x_i = '0;
  coord_t              dst_y_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  coord_t              vertex_x_o;
  coord_t              vertex_y_o;
  logic [CORNER_W-1:0] corner_index_o;
  logic                last_vertex_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [THICK_W-1:0]  cfg_line_thickness_i = '0;

  segment_t           segment_backlog[$];
  corner_t            corner_queue[$];
  logic [THICK_W-1:0] thickness_q = 8'd1;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  logic               hold_go = 1'b0;
  logic               hold_done = 1'b0;
  int                 hold_left = 0;

  thick_line_quad_vertices #(
    .ANGLE_STEPS(CORDIC_STEPS)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .src_x_i             (src_x_i),
    .src_y_i             (src_y_i),
    .dst_x_i             (dst_x_i),
    .dst_y_i             (dst_y_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .vertex_x_o          (vertex_x_o),
    .vertex_y_o          (vertex_y_o),
    .corner_index_o      (corner_index_o),
    .last_vertex_o       (last_vertex_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_line_thickness_i(cfg_line_thickness_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < 100) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  function automatic coord_t clamp_coord(input longint v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  function automatic void push_corner(input int k, input longint x, input longint y);
    corner_t cn;
    cn.x     = clamp_coord(x);
    cn.y     = clamp_coord(y);
    cn.index = k[CORNER_W-1:0];
    cn.last  = (cn.index == C_SRC_MINUS_B);
    corner_queue.push_back(cn);
  endfunction

  // offset vector by vectoring cordic, rotation of (H/K, 0) run in lockstep
  function automatic void predict_quad(input segment_t seg, input logic [THICK_W-1:0] thick);
    longint sx, sy, ex, ey, dx, dy, big_h, offx, offy;
    longint vx, vy, c, s, tx, ty, tc, ts;
    sx    = seg.src_x;
    sy    = seg.src_y;
    ex    = seg.dst_x;
    ey    = seg.dst_y;
    dx    = ex - sx;
    dy    = ey - sy;
    big_h = longint'(thick >> 1) * 16;
    if (dx == 0) begin
      offy = (dy == 0) ? big_h : 0;
      offx = (dy > 0) ? big_h : ((dy < 0) ? -big_h : 0);
    end else begin
      if (dx < 0) begin
        dx = -dx;
        dy = -dy;
      end
      vx = dx * 256;
      vy = dy * 256;
      c  = big_h * longint'(KINV_Q16);
      s  = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        tx = vx >>> i;
        ty = vy >>> i;
        tc = c >>> i;
        ts = s >>> i;
        if (vy >= 0) begin
          vx += ty;
          vy -= tx;
          c  -= ts;
          s  += tc;
        end else begin
          vx -= ty;
          vy += tx;
          c  += ts;
          s  -= tc;
        end
      end
      offx = (s + 32768) >>> 16;
      offy = (c + 32768) >>> 16;
    end
    push_corner(C_SRC_MINUS_A, sx - offx, sy + offy);
    push_corner(C_SRC_PLUS,    sx + offx, sy - offy);
    push_corner(C_DST_PLUS_A,  ex + offx, ey - offy);
    push_corner(C_DST_MINUS,   ex - offx, ey + offy);
    push_corner(C_DST_PLUS_B,  ex + offx, ey - offy);
    push_corner(C_SRC_MINUS_B, sx - offx, sy + offy);
  endfunction

  function automatic segment_t make_segment(input int sx, input int sy, input int ex,
                                            input int ey);
    segment_t g;
    g.src_x = coord_t'(sx);
    g.src_y = coord_t'(sy);
    g.dst_x = coord_t'(ex);
    g.dst_y = coord_t'(ey);
    return g;
  endfunction

  function automatic segment_t random_segment();
    segment_t g;
    int       pick;
    pick    = $urandom_range(0, 9);
    g.src_x = coord_t'($urandom);
    g.src_y = coord_t'($urandom);
    g.dst_x = coord_t'($urandom);
    g.dst_y = coord_t'($urandom);
    case (pick)
      5, 6, 7: begin
        // short segment, all angles at fine resolution
        g.dst_x = coord_t'(int'(g.src_x) + $urandom_range(0, 4096) - 2048);
        g.dst_y = coord_t'(int'(g.src_y) + $urandom_range(0, 4096) - 2048);
      end
      8: g.dst_x = g.src_x;
      9: begin
        g.dst_y = g.src_y;
        if ($urandom_range(0, 1)) g.dst_x = g.src_x;
      end
      default: ;
    endcase
    return g;
  endfunction

  // driver: presents queued segments, predicts each one on acceptance
  always @(posedge clk_i) begin
    segment_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_quad(make_segment(src_x_i, src_y_i, dst_x_i, dst_y_i), thickness_q);
      end
      if (!in_valid_i || in_ready_o) begin
        if (segment_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = segment_backlog.pop_front();
          src_x_i    <= nxt.src_x;
          src_y_i    <= nxt.src_y;
          dst_x_i    <= nxt.dst_x;
          dst_y_i    <= nxt.dst_y;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the pipeline fills and stalls the request side
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks each vertex against the oldest prediction
  always @(posedge clk_i) begin
    corner_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (corner_queue.size() == 0) begin
          flag_mismatch($sformatf("unexpected vertex x=%0d y=%0d corner=%0d",
                                  vertex_x_o, vertex_y_o, corner_index_o));
        end else begin
          want = corner_queue.pop_front();
          if (vertex_x_o !== want.x)
            flag_mismatch($sformatf("corner %0d vertex_x %0d, want %0d",
                                    want.index, vertex_x_o, want.x));
          if (vertex_y_o !== want.y)
            flag_mismatch($sformatf("corner %0d vertex_y %0d, want %0d",
                                    want.index, vertex_y_o, want.y));
          if (corner_index_o !== want.index)
            flag_mismatch($sformatf("corner_index %0d, want %0d", corner_index_o, want.index));
          if (last_vertex_o !== want.last)
            flag_mismatch($sformatf("corner %0d last_vertex %0b, want %0b",
                                    want.index, last_vertex_o, want.last));
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** thick_line_quad_vertices: FAILED **");
      $finish;
    end
  end

  task automatic drain();
    while (segment_backlog.size() != 0 || in_valid_i || corner_queue.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_thickness(input logic [THICK_W-1:0] v);
    cfg_valid_i          <= 1'b1;
    cfg_line_thickness_i <= v;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    thickness_q = v;
  endtask

  task automatic queue_random(input int n);
    repeat (n) segment_backlog.push_back(random_segment());
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset thickness of one pixel gives zero half width
    set_idling(0, 0);
    segment_backlog.push_back(make_segment(0, 0, 0, 0));
    segment_backlog.push_back(make_segment(16, 16, 16, 400));
    segment_backlog.push_back(make_segment(16, 400, 16, 16));
    segment_backlog.push_back(make_segment(0, 0, 160, 0));
    segment_backlog.push_back(make_segment(160, 0, 0, 0));
    segment_backlog.push_back(make_segment(0, 0, 100, 100));
    drain();

    // widest line: corners, saturation, vertical and zero-length cases
    write_thickness(8'd255);
    set_idling(48, 0);
    segment_backlog.push_back(make_segment(0, 0, 0, 0));
    segment_backlog.push_back(make_segment(-50, 20, -50, 900));
    segment_backlog.push_back(make_segment(-50, 900, -50, 20));
    segment_backlog.push_back(make_segment(-32768, -32768, 32767, 32767));
    segment_backlog.push_back(make_segment(32767, 32767, -32768, -32768));
    segment_backlog.push_back(make_segment(32767, -32768, -32768, 32767));
    segment_backlog.push_back(make_segment(-32768, 32767, 32767, -32768));
    segment_backlog.push_back(make_segment(32767, 0, 32767, -32768));
    segment_backlog.push_back(make_segment(-32768, 0, -32768, 32767));
    segment_backlog.push_back(make_segment(0, 32767, 0, 32767));
    segment_backlog.push_back(make_segment(0, -32768, 0, -32768));
    segment_backlog.push_back(make_segment(100, -50, -3000, -49));
    segment_backlog.push_back(make_segment(0, 0, 1, -32000));
    segment_backlog.push_back(make_segment(0, 0, 32767, 1));
    segment_backlog.push_back(make_segment(-1, -1, 0, 0));
    segment_backlog.push_back(make_segment(500, 20, -500, 20));
    queue_random(40);
    drain();

    write_thickness(8'd0);
    set_idling(0, 48);
    queue_random(50);
    drain();

    write_thickness(8'($urandom_range(4, 253)));
    set_idling(16, 16);
    queue_random(60);
    drain();

    // receiver held off while requests keep coming
    write_thickness(8'd254);
    set_idling(0, 0);
    hold_go <= 1'b1;
    queue_random(60);
    drain();

    write_thickness(8'd2);
    set_idling(48, 0);
    queue_random(50);
    drain();

    write_thickness(8'($urandom_range(1, 255)));
    set_idling(0, 48);
    queue_random(50);
    drain();

    if (mismatch_count == 0) begin
      $display("** thick_line_quad_vertices: PASSED **");
    end else begin
      $display("** thick_line_quad_vertices: FAILED **");
    end
    $finish;
  end

endmodule
